/* hw/rtl/brb_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Byte ring buffer package
// Shared codes, constants and payload types of the byte ring buffer.
// ---------------------------------------------------------------------------
package brb_pkg;

	localparam int RING_BYTES_DEF = 4096;
	localparam int MAX_READ_DEF   = 64;
	localparam int RING_CAP       = 4096;

	localparam logic [3:0] LG_MIN       = 4'd6;
	localparam logic [3:0] LG_MAX       = 4'd12;
	localparam logic [3:0] SIZE_LOG2_RST = 4'd12;

	typedef enum logic [2:0] {
		OP_RESET  = 3'd0,
		OP_WSTART = 3'd1,
		OP_WBYTE  = 3'd2,
		OP_READ   = 3'd3,
		OP_PEEK   = 3'd4,
		OP_SKIP   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVAL   = 2'd1,
		ST_NOSPACE = 2'd2,
		ST_NOWRITE = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [11:0] length;
		logic [7:0]  byte_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  byte_out;
		logic [11:0] count;
		logic        last;
		logic [11:0] space;
		logic [11:0] used;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic exec;
		logic fetch;
		logic cfg_we;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic multi;
		logic last;
	} dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/byte_ring_buffer.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Byte ring buffer
// Power-of-two byte FIFO with all-or-nothing writes, read, peek and skip.
// ---------------------------------------------------------------------------
// The block handles one item at a time. An item that gives a single result
// is executed at the accepting edge and its result is offered the next
// cycle, with the input stalled until that result transfers. A read or peek
// returning bytes is executed, then fetches each byte through the ring
// memory's registered read port before it is offered. A write to size_log2
// is taken only while no item is in flight and empties the ring. Ring
// contents are not cleared at reset; only bytes written since are ever
// returned.
module byte_ring_buffer #(
	parameter int RING_BYTES = brb_pkg::RING_BYTES_DEF,
	parameter int MAX_READ   = brb_pkg::MAX_READ_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  brb_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output brb_pkg::out_item_t   out_data,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [3:0]           cfg_data
);

	brb_pkg::ctrl_cmd_t cmd;
	brb_pkg::dp_stat_t  stat;

	brb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	brb_dp #(
		.RING_BYTES (RING_BYTES),
		.MAX_READ   (MAX_READ)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (in_data),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

/* hw/rtl/brb_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Byte ring buffer controller
// Sequences one item at a time: execute, then either one result or a
// fetch/emit loop over the bytes of a read or peek.
// ---------------------------------------------------------------------------
module brb_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire                   out_stall,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  brb_pkg::dp_stat_t     stat,
	output brb_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RESP  = 4'b0010,
		S_FETCH = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cfg_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				cfg_ready  = 1'b1;
				cmd.cfg_we = cfg_valid;
				// hold the input while a config write is taken
				in_stall   = cfg_valid;
				if (in_valid && !cfg_valid) begin
					cmd.exec = 1'b1;
					state_d  = stat.multi ? S_FETCH : S_RESP;
				end
			end
			S_RESP: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				out_valid = 1'b1;
				// advance to the next byte once this transfer completes
				if (!out_stall) begin
					state_d = stat.last ? S_IDLE : S_FETCH;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_fetch_then_show: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |=> (out_valid && !cmd.fetch))
		else $error("fetched byte not presented");

	a_no_exec_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!cmd.exec && !cmd.cfg_we))
		else $error("item or config taken while a result is pending");

endmodule
`default_nettype wire

/* hw/rtl/brb_dp.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Byte ring buffer datapath
// Ring memory, head/tail pointers, open write tracking and result fields.
// ---------------------------------------------------------------------------
module brb_dp #(
	parameter int RING_BYTES = brb_pkg::RING_BYTES_DEF,
	parameter int MAX_READ   = brb_pkg::MAX_READ_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  brb_pkg::ctrl_cmd_t    cmd,
	output brb_pkg::dp_stat_t     stat,
	input  brb_pkg::in_item_t     in_data,
	input  wire  [3:0]            cfg_data,
	output brb_pkg::out_item_t    out_data
);

	localparam int DEPTH = (RING_BYTES < brb_pkg::RING_CAP) ? RING_BYTES : brb_pkg::RING_CAP;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_READ + 1);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_data_q;

	logic [3:0]    size_log2_q;
	logic [AW-1:0] head_q, tail_q, wpos_q, rdp_q;
	logic [11:0]   pend_q;
	logic [RW-1:0] left_q;
	logic          multi_q;
	brb_pkg::status_t status_q;
	logic [11:0]   count_q;

	logic [AW-1:0] head_d, tail_d, wpos_d, rdp_d;
	logic [11:0]   pend_d;
	logic [RW-1:0] left_d;
	logic          multi_d;
	brb_pkg::status_t status_d;
	logic [11:0]   count_d;
	logic          wr_en;

	logic [3:0]    lg;
	logic [12:0]   size13;
	logic [AW-1:0] mask;
	logic [AW-1:0] used;
	logic [12:0]   space13;
	logic [11:0]   len;
	logic [11:0]   n12;
	logic [11:0]   nrd;

	// effective ring size from the register, clamped to LG_MIN..LG_MAX and to the memory depth
	always_comb begin
		lg = size_log2_q;
		if (lg < brb_pkg::LG_MIN) lg = brb_pkg::LG_MIN;
		if (lg > brb_pkg::LG_MAX) lg = brb_pkg::LG_MAX;
		if (lg > 4'(AW)) lg = 4'(AW);
		size13  = 13'(1) << lg;
		mask    = AW'(size13 - 13'(1));
		used    = (head_q - tail_q) & mask;
		space13 = size13 - 13'(used) - 13'(1);
	end

	assign len = in_data.length;

	always_comb begin
		n12 = (len < 12'(used)) ? len : 12'(used);
		nrd = (n12 > 12'(MAX_READ)) ? 12'(MAX_READ) : n12;
	end

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		wpos_d   = wpos_q;
		rdp_d    = rdp_q;
		pend_d   = pend_q;
		left_d   = left_q;
		multi_d  = multi_q;
		status_d = status_q;
		count_d  = count_q;
		wr_en    = 1'b0;
		if (cmd.exec) begin
			multi_d  = 1'b0;
			status_d = brb_pkg::ST_OK;
			count_d  = '0;
			unique case (in_data.op)
				brb_pkg::OP_RESET: begin
					head_d = '0;
					tail_d = '0;
					pend_d = '0;
				end
				brb_pkg::OP_WSTART: begin
					if (len == '0) begin
						status_d = brb_pkg::ST_INVAL;
					end else if (13'(len) > space13) begin
						status_d = brb_pkg::ST_NOSPACE;
					end else begin
						pend_d  = len;
						wpos_d  = head_q & mask;
						count_d = len;
					end
				end
				brb_pkg::OP_WBYTE: begin
					if (pend_q == '0) begin
						status_d = brb_pkg::ST_NOWRITE;
					end else begin
						wr_en   = 1'b1;
						wpos_d  = (wpos_q + AW'(1)) & mask;
						pend_d  = pend_q - 12'd1;
						count_d = 12'd1;
						// publish the write with its final byte
						if (pend_q == 12'd1) head_d = (wpos_q + AW'(1)) & mask;
					end
				end
				brb_pkg::OP_READ, brb_pkg::OP_PEEK: begin
					if (len == '0) begin
						status_d = brb_pkg::ST_INVAL;
					end else if (nrd != '0) begin
						multi_d = 1'b1;
						left_d  = RW'(nrd);
						rdp_d   = tail_q;
						count_d = nrd;
						if (in_data.op == brb_pkg::OP_READ) begin
							tail_d = (tail_q + AW'(nrd)) & mask;
						end
					end
				end
				brb_pkg::OP_SKIP: begin
					if (len > 12'(used)) begin
						status_d = brb_pkg::ST_INVAL;
					end else begin
						tail_d  = (tail_q + AW'(len)) & mask;
						count_d = len;
					end
				end
				default: begin
					status_d = brb_pkg::ST_INVAL;
				end
			endcase
		end
		if (cmd.fetch) begin
			rdp_d  = (rdp_q + AW'(1)) & mask;
			left_d = left_q - RW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= brb_pkg::SIZE_LOG2_RST;
			head_q      <= '0;
			tail_q      <= '0;
			wpos_q      <= '0;
			pend_q      <= '0;
			multi_q     <= 1'b0;
			left_q      <= '0;
		end else if (cmd.cfg_we) begin
			// a new size re-initializes the ring
			size_log2_q <= cfg_data;
			head_q      <= '0;
			tail_q      <= '0;
			wpos_q      <= '0;
			pend_q      <= '0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			wpos_q  <= wpos_d;
			pend_q  <= pend_d;
			multi_q <= multi_d;
			left_q  <= left_d;
		end
	end

	always_ff @(posedge clk) begin
		rdp_q    <= rdp_d;
		status_q <= status_d;
		count_q  <= count_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wpos_q & mask] <= in_data.byte_in;
		end
		if (cmd.fetch) begin
			rd_data_q <= mem[rdp_q];
		end
	end

	assign stat.multi = multi_d;
	assign stat.last  = (left_q == '0);

	always_comb begin
		out_data.status   = status_q;
		out_data.byte_out = multi_q ? rd_data_q : 8'd0;
		out_data.count    = count_q;
		out_data.last     = multi_q ? (left_q == '0) : 1'b1;
		out_data.space    = 12'(space13);
		out_data.used     = 12'(used);
	end

	a_ptrs_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		((head_q & ~mask) == '0) && ((tail_q & ~mask) == '0))
		else $error("ring pointer beyond ring size");

	a_open_write_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != '0) |-> (13'(pend_q) <= space13))
		else $error("open write exceeds free space");

	a_read_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> (left_q != '0))
		else $error("byte fetched past read length");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// ---------------------------------------------------------------------------
// Byte ring buffer testbench
// Drives write, read, peek, skip and reset items into the ring under random
// stalls on both channels, tracks head, tail and the open write in a local
// model of the ring, and checks every returned result field by field.
// ---------------------------------------------------------------------------
module tb;
	import brb_pkg::*;

	localparam logic [2:0] OP_UNDEF_LO = 3'd6;
	localparam logic [2:0] OP_UNDEF_HI = 3'd7;
	localparam int         STALL_LIMIT = 2000;

	class ring_tracker;
		logic [7:0]  mem [RING_BYTES_DEF];
		logic [11:0] head;
		logic [11:0] tail;
		logic [11:0] pend;
		logic [11:0] wpos;
		logic [3:0]  lg;
		out_item_t   pending_results [$];
		int          mismatches;

		function new();
			lg = SIZE_LOG2_RST;
			head = '0;
			tail = '0;
			pend = '0;
			wpos = '0;
			mismatches = 0;
		endfunction

		function void set_size(logic [3:0] v);
			lg = v;
			head = '0;
			tail = '0;
			pend = '0;
			wpos = '0;
		endfunction

		function int ring_bytes();
			int l;
			l = int'(lg);
			if (l < LG_MIN) l = LG_MIN;
			if (l > LG_MAX) l = LG_MAX;
			l = 1 << l;
			return (l > RING_BYTES_DEF) ? RING_BYTES_DEF : l;
		endfunction

		function int used_bytes();
			return (head - tail) & (ring_bytes() - 1);
		endfunction

		function int space_bytes();
			return ring_bytes() - used_bytes() - 1;
		endfunction

		function void push(status_t st, logic [7:0] b, logic [11:0] cnt, logic lst);
			out_item_t r;
			r.status   = st;
			r.byte_out = b;
			r.count    = cnt;
			r.last     = lst;
			r.space    = 12'(space_bytes());
			r.used     = 12'(used_bytes());
			pending_results.push_back(r);
		endfunction

		function void predict_item(in_item_t it);
			int          n;
			int          i;
			logic [11:0] mask;
			logic [11:0] t;
			logic [7:0]  taken [MAX_READ_DEF];
			mask = 12'(ring_bytes() - 1);
			case (it.op)
				OP_RESET: begin
					head = '0;
					tail = '0;
					pend = '0;
					push(ST_OK, 8'd0, 12'd0, 1'b1);
				end
				OP_WSTART: begin
					if (it.length == 0) begin
						push(ST_INVAL, 8'd0, 12'd0, 1'b1);
					end else if (it.length > space_bytes()) begin
						push(ST_NOSPACE, 8'd0, 12'd0, 1'b1);
					end else begin
						pend = it.length;
						wpos = head & mask;
						push(ST_OK, 8'd0, it.length, 1'b1);
					end
				end
				OP_WBYTE: begin
					if (pend == 0) begin
						push(ST_NOWRITE, 8'd0, 12'd0, 1'b1);
					end else begin
						wpos = wpos & mask;
						mem[wpos] = it.byte_in;
						wpos = (wpos + 12'd1) & mask;
						pend = pend - 12'd1;
						// publish the write only once its last byte is in
						if (pend == 0) head = wpos;
						push(ST_OK, 8'd0, 12'd1, 1'b1);
					end
				end
				OP_READ, OP_PEEK: begin
					if (it.length == 0) begin
						push(ST_INVAL, 8'd0, 12'd0, 1'b1);
					end else begin
						n = int'(it.length);
						if (n > used_bytes()) n = used_bytes();
						if (n > MAX_READ_DEF) n = MAX_READ_DEF;
						if (n == 0) begin
							push(ST_OK, 8'd0, 12'd0, 1'b1);
						end else begin
							t = tail & mask;
							for (i = 0; i < n; i++) taken[i] = mem[(t + 12'(i)) & mask];
							if (it.op == OP_READ) tail = (t + 12'(n)) & mask;
							for (i = 0; i < n; i++) push(ST_OK, taken[i], 12'(n), i == n - 1);
						end
					end
				end
				OP_SKIP: begin
					if (it.length > used_bytes()) begin
						push(ST_INVAL, 8'd0, 12'd0, 1'b1);
					end else begin
						tail = (tail + it.length) & mask;
						push(ST_OK, 8'd0, it.length, 1'b1);
					end
				end
				default: push(ST_INVAL, 8'd0, 12'd0, 1'b1);
			endcase
		endfunction

		function string fmt(out_item_t r);
			return $sformatf("status=%0d byte=%02h count=%0d last=%0b space=%0d used=%0d",
				r.status, r.byte_out, r.count, r.last, r.space, r.used);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) $display("[ring] %s", msg);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			string     bad;
			if (pending_results.size() == 0) begin
				flag({"result with nothing outstanding: ", fmt(got)});
				return;
			end
			exp = pending_results.pop_front();
			bad = "";
			if (got.status !== exp.status) bad = {bad, " status"};
			if (got.byte_out !== exp.byte_out) bad = {bad, " byte_out"};
			if (got.count !== exp.count) bad = {bad, " count"};
			if (got.last !== exp.last) bad = {bad, " last"};
			if (got.space !== exp.space) bad = {bad, " space"};
			if (got.used !== exp.used) bad = {bad, " used"};
			if (bad != "")
				flag({"mismatch in", bad, ": expected ", fmt(exp), " got ", fmt(got)});
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [3:0] cfg_data = '0;

	ring_tracker tracker = new();
	bit          idle_on = 1'b1;
	int          items_sent = 0;
	int          quiet_cycles = 0;

	byte_ring_buffer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) tracker.check_result(out_data);
	end

	// end the run if no transfer of any kind happens for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// called and returning at a falling edge; valid stays up after the transfer
	task automatic send_item(input logic [2:0] op, input logic [11:0] len,
	                         input logic [7:0] b);
		in_item_t it;
		it.op      = op;
		it.length  = len;
		it.byte_in = b;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.predict_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (tracker.pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_ring_size(input logic [3:0] v);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_size(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [11:0] pick_len(int used_now);
		int hi;
		hi = (used_now + 2 > 4095) ? 4095 : used_now + 2;
		case ($urandom_range(0, 7))
			0:       return 12'd0;
			1:       return 12'hFFF;
			2:       return 12'($urandom_range(0, 4095));
			default: return 12'($urandom_range(1, hi));
		endcase
	endfunction

	task automatic run_random(input int budget);
		int start;
		int pick;
		int n;
		int k;
		int space_now;
		start = items_sent;
		while (items_sent - start < budget) begin
			pick = $urandom_range(0, 99);
			space_now = tracker.space_bytes();
			if (pick < 45) begin
				case ($urandom_range(0, 9))
					0:       n = space_now + 1;
					1:       n = (space_now < 40) ? space_now : $urandom_range(13, 40);
					default: n = $urandom_range(1, 12);
				endcase
				if (n > 4095) n = 4095;
				send_item(OP_WSTART, 12'(n), 8'($urandom_range(0, 255)));
				// a long accepted start stays open and is dropped by a later one
				if (n > 0 && n <= space_now && n <= 40) begin
					// cut a write short now and then; the next start drops it
					k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : n;
					repeat (k) send_item(OP_WBYTE, 12'($urandom_range(0, 4095)),
						8'($urandom_range(0, 255)));
				end
			end else if (pick < 70) begin
				send_item(OP_READ, pick_len(tracker.used_bytes()), 8'($urandom_range(0, 255)));
			end else if (pick < 82) begin
				send_item(OP_PEEK, pick_len(tracker.used_bytes()), 8'($urandom_range(0, 255)));
			end else if (pick < 92) begin
				send_item(OP_SKIP, pick_len(tracker.used_bytes()) - 12'd1,
					8'($urandom_range(0, 255)));
			end else if (pick < 94) begin
				wait_results_drained();
			end else begin
				case ($urandom_range(0, 3))
					0: send_item(OP_WBYTE, 12'($urandom_range(0, 4095)),
						8'($urandom_range(0, 255)));
					1: send_item(OP_UNDEF_LO, 12'($urandom_range(0, 4095)),
						8'($urandom_range(0, 255)));
					2: send_item(OP_UNDEF_HI, 12'($urandom_range(0, 4095)),
						8'($urandom_range(0, 255)));
					default: send_item(OP_RESET, 12'($urandom_range(0, 4095)),
						8'($urandom_range(0, 255)));
				endcase
			end
		end
	endtask

	logic [3:0] size_plan [6] = '{4'd6, 4'd15, 4'd7, 4'd0, 4'd9, 4'd12};

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty ring, stray byte, zero lengths
		send_item(OP_READ, 12'd5, 8'h00);
		send_item(OP_PEEK, 12'hFFF, 8'hFF);
		send_item(OP_WBYTE, 12'hFFF, 8'hFF);
		send_item(OP_WSTART, 12'd0, 8'h00);
		// full-size start accepted, then dropped by a new start
		send_item(OP_WSTART, 12'hFFF, 8'h00);
		send_item(OP_WSTART, 12'd3, 8'h00);
		send_item(OP_WBYTE, 12'd0, 8'h00);
		send_item(OP_WBYTE, 12'd0, 8'hFF);
		send_item(OP_WBYTE, 12'd0, 8'hA5);
		send_item(OP_WSTART, 12'd4093, 8'h00);
		send_item(OP_READ, 12'd0, 8'h00);
		send_item(OP_PEEK, 12'd0, 8'h00);
		send_item(OP_PEEK, 12'd2, 8'h00);
		send_item(OP_SKIP, 12'd0, 8'h00);
		send_item(OP_SKIP, 12'd4, 8'h00);
		send_item(OP_SKIP, 12'd1, 8'h00);
		send_item(OP_READ, 12'hFFF, 8'h00);
		send_item(OP_UNDEF_LO, 12'd1, 8'h00);
		send_item(OP_UNDEF_HI, 12'hFFF, 8'hFF);
		// reset op drops an open write
		send_item(OP_WSTART, 12'd2, 8'h00);
		send_item(OP_WBYTE, 12'd0, 8'h5A);
		send_item(OP_RESET, 12'hFFF, 8'hFF);
		send_item(OP_WBYTE, 12'd0, 8'h3C);

		foreach (size_plan[p]) begin
			if (p == 5) idle_on = 1'b0;
			write_ring_size(size_plan[p]);
			if (size_plan[p] == 4'd7) begin
				// fill past the read cap, then take the longest read and a peek
				send_item(OP_WSTART, 12'd66, 8'h00);
				repeat (66) send_item(OP_WBYTE, 12'd0, 8'($urandom_range(0, 255)));
				send_item(OP_READ, 12'hFFF, 8'h00);
				send_item(OP_PEEK, 12'hFFF, 8'h00);
			end
			run_random(15);
		end

		wait_results_drained();
		repeat (20) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
